### src/pfke_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfke_pkg: shared types and constants of the flow key extractor
// Frame byte and flow key payloads, parse state record, protocol numbers
// and result status codes.
// ----------------------------------------------------------------------------
package pfke_pkg;

	localparam logic [7:0]   ETH_HDR_LEN    = 8'd14;
	localparam logic [7:0]   IPV6_L4_START  = 8'd54;
	localparam logic [7:0]   IPV4_MIN_END   = 8'd34;
	localparam logic [15:0]  ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [15:0]  ETHERTYPE_IPV6 = 16'h86DD;
	localparam logic [7:0]   PROTO_TCP      = 8'd6;
	localparam logic [7:0]   PROTO_UDP      = 8'd17;
	localparam logic [127:0] V4_MAPPED_BASE = 128'h0000_0000_0000_0000_0000_FFFF_0000_0000;

	// TCP flag bit positions
	localparam int FLAG_FIN_BIT = 0;
	localparam int FLAG_SYN_BIT = 1;
	localparam int FLAG_RST_BIT = 2;
	localparam int FLAG_ACK_BIT = 4;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_ETHER   = 3'd1,
		ST_BAD_IHL     = 3'd2,
		ST_BAD_L4      = 3'd3,
		ST_TRUNCATED   = 3'd4,
		ST_SAME_ADDR   = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} frame_byte_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] ether_kind;
		logic [63:0] src_addr_high;
		logic [63:0] src_addr_low;
		logic [63:0] dst_addr_high;
		logic [63:0] dst_addr_low;
		logic [7:0]  l4_proto;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [10:0] flow_flags;
	} flow_key_t;

	typedef struct packed {
		logic [7:0]   byte_index;
		logic [15:0]  ether_word;
		logic [7:0]   transport_start;
		logic [5:0]   tcp_header_bytes;
		logic [7:0]   proto;
		logic [127:0] src_addr;
		logic [127:0] dst_addr;
		logic [31:0]  port_pair;
		logic [7:0]   tcp_flag_byte;
	} parse_state_t;

endpackage

### src/pfke_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfke_parse: per-frame header field capture
// Holds the parse state and captures each header field at its fixed or
// computed byte offset as the frame streams past, one byte per step.
// ----------------------------------------------------------------------------
module pfke_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	output pfke_pkg::parse_state_t cap,
	output logic [7:0]            frame_len
);

	localparam logic [7:0] OFF_ETYPE_HI  = 8'd12;
	localparam logic [7:0] OFF_ETYPE_LO  = 8'd13;
	localparam logic [7:0] OFF_V4_IHL    = 8'd14;
	localparam logic [7:0] OFF_V4_PROTO  = 8'd23;
	localparam logic [7:0] OFF_V4_SRC    = 8'd26;
	localparam logic [7:0] OFF_V4_DST    = 8'd30;
	localparam logic [7:0] OFF_V4_END    = 8'd33;
	localparam logic [7:0] OFF_V6_PROTO  = 8'd20;
	localparam logic [7:0] OFF_V6_SRC    = 8'd22;
	localparam logic [7:0] OFF_V6_DST    = 8'd38;
	localparam logic [7:0] OFF_V6_END    = 8'd53;
	localparam logic [7:0] L4_OFF_DOFF   = 8'd12;
	localparam logic [7:0] L4_OFF_FLAGS  = 8'd13;
	localparam logic [7:0] IDX_SAT       = 8'hFF;

	pfke_pkg::parse_state_t state_q;
	pfke_pkg::parse_state_t state_d;

	logic [7:0] idx;
	logic       live;
	logic [7:0] v4_src_pos;
	logic [7:0] v4_dst_pos;
	logic [7:0] v6_src_pos;
	logic [7:0] v6_dst_pos;
	logic [7:0] l4_off;

	assign idx        = state_q.byte_index;
	assign live       = (idx != IDX_SAT);
	assign frame_len  = live ? idx + 8'd1 : IDX_SAT;
	assign v4_src_pos = idx - 8'd14;
	assign v4_dst_pos = idx - 8'd18;
	assign v6_src_pos = idx - OFF_V6_SRC;
	assign v6_dst_pos = idx - OFF_V6_DST;
	assign l4_off     = idx - state_q.transport_start;

	always_comb begin
		cap = state_q;
		if (live) begin
			if (idx == OFF_ETYPE_HI) begin
				cap.ether_word[15:8] = data_byte;
			end
			if (idx == OFF_ETYPE_LO) begin
				cap.ether_word[7:0] = data_byte;
				if ({state_q.ether_word[15:8], data_byte} == pfke_pkg::ETHERTYPE_IPV4) begin
					cap.src_addr = pfke_pkg::V4_MAPPED_BASE;
					cap.dst_addr = pfke_pkg::V4_MAPPED_BASE;
				end else if ({state_q.ether_word[15:8], data_byte} ==
						pfke_pkg::ETHERTYPE_IPV6) begin
					cap.transport_start = pfke_pkg::IPV6_L4_START;
				end
			end
			if (state_q.ether_word == pfke_pkg::ETHERTYPE_IPV4 && idx >= OFF_V4_IHL) begin
				if (idx == OFF_V4_IHL) begin
					cap.transport_start = pfke_pkg::ETH_HDR_LEN +
						{2'b00, data_byte[3:0], 2'b00};
				end
				if (idx == OFF_V4_PROTO) begin
					cap.proto = data_byte;
				end
				if (idx >= OFF_V4_SRC && idx < OFF_V4_DST) begin
					cap.src_addr[{~v4_src_pos[3:0], 3'b000} +: 8] = data_byte;
				end
				if (idx >= OFF_V4_DST && idx <= OFF_V4_END) begin
					cap.dst_addr[{~v4_dst_pos[3:0], 3'b000} +: 8] = data_byte;
				end
			end else if (state_q.ether_word == pfke_pkg::ETHERTYPE_IPV6 &&
					idx >= OFF_V4_IHL) begin
				if (idx == OFF_V6_PROTO) begin
					cap.proto = data_byte;
				end
				if (idx >= OFF_V6_SRC && idx < OFF_V6_DST) begin
					cap.src_addr[{~v6_src_pos[3:0], 3'b000} +: 8] = data_byte;
				end
				if (idx >= OFF_V6_DST && idx <= OFF_V6_END) begin
					cap.dst_addr[{~v6_dst_pos[3:0], 3'b000} +: 8] = data_byte;
				end
			end
			// transport header: ports, data offset, flag byte
			if (state_q.transport_start != 8'd0 && idx > OFF_V4_IHL &&
					idx >= state_q.transport_start) begin
				if (l4_off < 8'd4) begin
					cap.port_pair[{~l4_off[1:0], 3'b000} +: 8] = data_byte;
				end else if (l4_off == L4_OFF_DOFF) begin
					cap.tcp_header_bytes = {data_byte[7:4], 2'b00};
				end else if (l4_off == L4_OFF_FLAGS) begin
					cap.tcp_flag_byte = data_byte;
				end
			end
		end
	end

	// drop all frame state after the last byte
	always_comb begin
		state_d = state_q;
		if (step) begin
			if (last_byte) begin
				state_d = '0;
			end else begin
				state_d            = cap;
				state_d.byte_index = frame_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### src/packet_flow_key_extractor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_flow_key_extractor_core: Ethernet/IP/TCP/UDP flow key extractor
// Parses a frame one byte per transfer and emits one flow key per frame.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-----------------------------
//  byte      | in  | byte_valid/byte_ready  | byte_data  (frame_byte_t)
//  key       | out | key_valid/key_ready    | key_data   (flow_key_t)
//
//  One byte transfer per cycle while the input stage does not stall. A byte
//  waits in the input stage, where the parse state captures it; on the last
//  byte the checks run in the same cycle and the key lands in the result
//  register as that byte leaves the input stage.
//  Stalls: only a last byte that finds the result register full and not
//  taken holds the input stage.
//  Reset clears the input stage, the parse state and the result valid.
// ----------------------------------------------------------------------------
module packet_flow_key_extractor_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  pfke_pkg::frame_byte_t byte_data,
	output logic                  key_valid,
	input  logic                  key_ready,
	output pfke_pkg::flow_key_t   key_data
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;

	// result register
	logic                key_valid_q;
	pfke_pkg::flow_key_t key_q;
	pfke_pkg::flow_key_t key_d;

	pfke_pkg::parse_state_t cap;
	logic [7:0]             frame_len;
	pfke_pkg::status_t      status;
	logic [8:0]             len9;
	logic [8:0]             ts9;
	logic [10:0]            flags;

	// advance a non-last byte always; a last byte needs a free result slot
	assign advance    = valid_s1 && (!last_s1 || !key_valid_q || key_ready);
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= byte_data.data_byte;
			last_s1 <= byte_data.last_byte;
		end
	end

	pfke_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cap       (cap),
		.frame_len (frame_len)
	);

	assign len9 = {1'b0, frame_len};
	assign ts9  = {1'b0, cap.transport_start};

	// checks in order; the first failure sets the status
	always_comb begin
		status = pfke_pkg::ST_OK;
		priority if (len9 < {1'b0, pfke_pkg::ETH_HDR_LEN}) begin
			status = pfke_pkg::ST_TRUNCATED;
		end else if (cap.ether_word != pfke_pkg::ETHERTYPE_IPV4 &&
				cap.ether_word != pfke_pkg::ETHERTYPE_IPV6) begin
			status = pfke_pkg::ST_BAD_ETHER;
		end else if (cap.ether_word == pfke_pkg::ETHERTYPE_IPV4 &&
				len9 < {1'b0, pfke_pkg::ETH_HDR_LEN} + 9'd1) begin
			status = pfke_pkg::ST_TRUNCATED;
		end else if (cap.ether_word == pfke_pkg::ETHERTYPE_IPV4 &&
				ts9 < {1'b0, pfke_pkg::IPV4_MIN_END}) begin
			status = pfke_pkg::ST_BAD_IHL;
		end else if (cap.ether_word == pfke_pkg::ETHERTYPE_IPV4 && len9 < ts9) begin
			status = pfke_pkg::ST_TRUNCATED;
		end else if (cap.ether_word == pfke_pkg::ETHERTYPE_IPV6 &&
				len9 < {1'b0, pfke_pkg::IPV6_L4_START}) begin
			status = pfke_pkg::ST_TRUNCATED;
		end else if (cap.proto != pfke_pkg::PROTO_TCP &&
				cap.proto != pfke_pkg::PROTO_UDP) begin
			status = pfke_pkg::ST_BAD_L4;
		end else if (cap.proto == pfke_pkg::PROTO_TCP &&
				(len9 < ts9 + 9'd14 ||
				len9 < ts9 + {3'b000, cap.tcp_header_bytes})) begin
			status = pfke_pkg::ST_TRUNCATED;
		end else if (cap.proto == pfke_pkg::PROTO_UDP && len9 < ts9 + 9'd8) begin
			status = pfke_pkg::ST_TRUNCATED;
		end else if (cap.src_addr == cap.dst_addr) begin
			status = pfke_pkg::ST_SAME_ADDR;
		end else begin
			status = pfke_pkg::ST_OK;
		end
	end

	// combined flags need ACK plus the other bit; SYN-ACK wins, then FIN, then RST
	always_comb begin
		flags = 11'd0;
		if (cap.proto == pfke_pkg::PROTO_TCP) begin
			flags[7:0] = cap.tcp_flag_byte;
			priority if (cap.tcp_flag_byte[pfke_pkg::FLAG_ACK_BIT] &&
					cap.tcp_flag_byte[pfke_pkg::FLAG_SYN_BIT]) begin
				flags[8] = 1'b1;
			end else if (cap.tcp_flag_byte[pfke_pkg::FLAG_ACK_BIT] &&
					cap.tcp_flag_byte[pfke_pkg::FLAG_FIN_BIT]) begin
				flags[9] = 1'b1;
			end else if (cap.tcp_flag_byte[pfke_pkg::FLAG_ACK_BIT] &&
					cap.tcp_flag_byte[pfke_pkg::FLAG_RST_BIT]) begin
				flags[10] = 1'b1;
			end else begin
				flags[10:8] = 3'b000;
			end
		end
	end

	// zero every field but status and ethertype on a rejected frame
	always_comb begin
		key_d            = '0;
		key_d.status     = status;
		key_d.ether_kind = cap.ether_word;
		if (status == pfke_pkg::ST_OK) begin
			key_d.src_addr_high = cap.src_addr[127:64];
			key_d.src_addr_low  = cap.src_addr[63:0];
			key_d.dst_addr_high = cap.dst_addr[127:64];
			key_d.dst_addr_low  = cap.dst_addr[63:0];
			key_d.l4_proto      = cap.proto;
			key_d.source_port   = cap.port_pair[31:16];
			key_d.dest_port     = cap.port_pair[15:0];
			key_d.flow_flags    = flags;
		end
	end

	// hold the key until its transfer; load a new one on each last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			key_valid_q <= 1'b1;
		end else if (key_ready) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			key_q <= key_d;
		end
	end

	assign key_valid = key_valid_q;
	assign key_data  = key_q;

`ifndef SYNTH
	a_reject_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_data.status != pfke_pkg::ST_OK |->
			key_data.l4_proto == 8'd0 && key_data.source_port == 16'd0 &&
			key_data.dest_port == 16'd0 && key_data.flow_flags == 11'd0)
		else $error("rejected key carries nonzero fields");

	a_ok_transport: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_data.status == pfke_pkg::ST_OK |->
			(key_data.l4_proto == pfke_pkg::PROTO_TCP ||
			key_data.l4_proto == pfke_pkg::PROTO_UDP))
		else $error("accepted key with unsupported transport");

	a_ok_ether: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid && key_data.status == pfke_pkg::ST_OK |->
			(key_data.ether_kind == pfke_pkg::ETHERTYPE_IPV4 ||
			key_data.ether_kind == pfke_pkg::ETHERTYPE_IPV6))
		else $error("accepted key with unsupported ethertype");

	a_flag_marks: assert property (@(posedge clk) disable iff (!arst_n)
		key_valid |-> $onehot0(key_data.flow_flags[10:8]))
		else $error("more than one combined flag set");

	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> key_valid)
		else $error("last byte did not produce a key");
`endif

endmodule

### dv/packet_flow_key_extractor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_flow_key_extractor_core_test: flow key extractor testbench
// Streams Ethernet frames into the parser one byte per transfer. A directed
// table comes first, then random frames under several idle and stall mixes,
// then a long key-side hold-off. The shadow parser or a typed recipe
// gives each expected key, and each key out is compared field by field.
// ----------------------------------------------------------------------------
module packet_flow_key_extractor_core_test;

	localparam int          CYCLE_LIMIT   = 60_000;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          HOLD_FRAMES   = 3;
	localparam int          PHASE_BYTES   = 100;
	localparam int          DRAIN_CYCLES  = 16;
	localparam int          TCP_MIN_LEN   = 14;
	localparam int          UDP_HDR_LEN   = 8;
	localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
	localparam logic [15:0] ETH_V4        = pfke_pkg::ETHERTYPE_IPV4;
	localparam logic [15:0] ETH_V6        = pfke_pkg::ETHERTYPE_IPV6;

	// Combined flag marks above the TCP flag byte
	localparam int MARK_SYN_ACK_BIT = 8;
	localparam int MARK_FIN_ACK_BIT = 9;
	localparam int MARK_RST_ACK_BIT = 10;

	// Well-formed IP shapes come first so a random pick can draw from them alone
	typedef enum logic [3:0] {
		F_V4_TCP,
		F_V4_UDP,
		F_V6_TCP,
		F_V6_UDP,
		F_V4_OTHER,
		F_V6_OTHER,
		F_ARP,
		F_ALL_ZERO,
		F_ALL_ONES
	} frame_shape_t;

	// One frame recipe. len 0 keeps the natural length. When typed is set the
	// key is status and ether_kind as given, every other field zero.
	typedef struct packed {
		frame_shape_t      shape;
		int                len;
		int                ihl;
		int                doff;
		logic [7:0]        tcp_flags;
		bit                twin;
		bit                typed;
		pfke_pkg::status_t st;
		logic [15:0]       ek;
	} frame_row_t;

	frame_row_t directed_rows [25] = '{
		// runt frames, all-zero and all-one bytes
		'{F_ALL_ZERO, 1,   5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, 16'h0000},
		'{F_ALL_ONES, 13,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, 16'hFF00},
		'{F_ALL_ZERO, 20,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_ETHER, 16'h0000},
		'{F_ALL_ONES, 20,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_ETHER, 16'hFFFF},
		'{F_ARP,      20,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_ETHER, ETHERTYPE_ARP},
		// IPv4 cut at the ethertype, IHL below five, header cut short
		'{F_V4_TCP,   14,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, ETH_V4},
		'{F_V4_TCP,   15,  4, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_IHL,   ETH_V4},
		'{F_V4_UDP,   15,  0, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_IHL,   ETH_V4},
		'{F_V4_TCP,   50, 15, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, ETH_V4},
		'{F_V6_TCP,   53,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, ETH_V6},
		// other transport, short TCP and UDP, equal addresses
		'{F_V4_OTHER, 34,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_L4,    ETH_V4},
		'{F_V6_OTHER, 54,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_BAD_L4,    ETH_V6},
		'{F_V4_TCP,   47,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, ETH_V4},
		'{F_V4_TCP,   80,  5, 15, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, ETH_V4},
		'{F_V6_UDP,   61,  5, 5, 8'h00, 1'b0, 1'b1, pfke_pkg::ST_TRUNCATED, ETH_V6},
		'{F_V4_TCP,   0,   5, 5, 8'h10, 1'b1, 1'b1, pfke_pkg::ST_SAME_ADDR, ETH_V4},
		'{F_V6_UDP,   0,   5, 5, 8'h00, 1'b1, 1'b1, pfke_pkg::ST_SAME_ADDR, ETH_V6},
		// good frames: combined flags, IPv4 options, small data offset, edges
		'{F_V4_TCP,   0,   5, 5, 8'h12, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V4_TCP,   0,   7, 8, 8'h11, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V6_TCP,   0,   5, 2, 8'h14, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V6_TCP,   0,   5, 5, 8'h17, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V4_TCP,   0,   5, 5, 8'h07, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V4_UDP,   42,  5, 5, 8'h00, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V6_TCP,   256, 5, 5, 8'hFF, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000},
		'{F_V4_TCP,   0,   5, 15, 8'h10, 1'b0, 1'b0, pfke_pkg::ST_OK, 16'h0000}
	};

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	pfke_pkg::frame_byte_t byte_data  = '0;
	logic                  key_valid;
	logic                  key_ready  = 1'b0;
	pfke_pkg::flow_key_t   key_data;

	// Bytes of the frame being sent, keys still owed by the block
	logic [7:0]          frame_buf [$];
	pfke_pkg::flow_key_t pending_keys [$];

	// Shadow copy of the parse state
	pfke_pkg::parse_state_t shadow = '0;

	int mismatch_count = 0;
	int cycle_count    = 0;
	int src_idle_pct   = 0;
	int rcv_stall_pct  = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	packet_flow_key_extractor_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.key_valid  (key_valid),
		.key_ready  (key_ready),
		.key_data   (key_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Place byte b at position p of a 16-byte big-endian address.
	function automatic logic [127:0] set_addr_byte(logic [127:0] addr, int p, logic [7:0] b);
		addr[127 - 8 * p -: 8] = b;
		return addr;
	endfunction

	// Status of a frame of len bytes, first failing check wins.
	function automatic pfke_pkg::status_t frame_status(int len);
		int ts;
		int tcp_len;
		ts = int'(shadow.transport_start);
		tcp_len = int'(shadow.tcp_header_bytes);
		if (len < int'(pfke_pkg::ETH_HDR_LEN))
			return pfke_pkg::ST_TRUNCATED;
		if (shadow.ether_word == pfke_pkg::ETHERTYPE_IPV4) begin
			if (len < int'(pfke_pkg::ETH_HDR_LEN) + 1)
				return pfke_pkg::ST_TRUNCATED;
			if (ts < int'(pfke_pkg::IPV4_MIN_END))
				return pfke_pkg::ST_BAD_IHL;
			if (len < ts)
				return pfke_pkg::ST_TRUNCATED;
		end else if (shadow.ether_word == pfke_pkg::ETHERTYPE_IPV6) begin
			if (len < int'(pfke_pkg::IPV6_L4_START))
				return pfke_pkg::ST_TRUNCATED;
		end else begin
			return pfke_pkg::ST_BAD_ETHER;
		end
		if (shadow.proto == pfke_pkg::PROTO_TCP) begin
			if (len < ts + TCP_MIN_LEN || len < ts + tcp_len)
				return pfke_pkg::ST_TRUNCATED;
		end else if (shadow.proto == pfke_pkg::PROTO_UDP) begin
			if (len < ts + UDP_HDR_LEN)
				return pfke_pkg::ST_TRUNCATED;
		end else begin
			return pfke_pkg::ST_BAD_L4;
		end
		if (shadow.src_addr == shadow.dst_addr)
			return pfke_pkg::ST_SAME_ADDR;
		return pfke_pkg::ST_OK;
	endfunction

	// Advance the shadow parser by one accepted byte; on the last byte form
	// the flow key and clear the parse state.
	task automatic track_byte(input pfke_pkg::frame_byte_t fb, output bit done,
			output pfke_pkg::flow_key_t key);
		logic [7:0]        idx;
		logic [7:0]        b;
		logic [31:0]       ports;
		logic [10:0]       fl;
		int                off;
		int                len;
		pfke_pkg::status_t st;
		idx = shadow.byte_index;
		b = fb.data_byte;
		done = 1'b0;
		key = '0;
		if (idx != 8'd255) begin
			if (idx == 8'd12)
				shadow.ether_word[15:8] = b;
			if (idx == 8'd13) begin
				shadow.ether_word[7:0] = b;
				if (shadow.ether_word == pfke_pkg::ETHERTYPE_IPV4) begin
					shadow.src_addr = pfke_pkg::V4_MAPPED_BASE;
					shadow.dst_addr = pfke_pkg::V4_MAPPED_BASE;
				end else if (shadow.ether_word == pfke_pkg::ETHERTYPE_IPV6) begin
					shadow.transport_start = pfke_pkg::IPV6_L4_START;
				end
			end
			// IPv4 addresses land in the low four bytes of the mapped address
			if (shadow.ether_word == pfke_pkg::ETHERTYPE_IPV4 && idx >= 8'd14) begin
				if (idx == 8'd14)
					shadow.transport_start = pfke_pkg::ETH_HDR_LEN + {2'b00, b[3:0], 2'b00};
				if (idx == 8'd23)
					shadow.proto = b;
				if (idx >= 8'd26 && idx <= 8'd29)
					shadow.src_addr = set_addr_byte(shadow.src_addr, 12 + idx - 26, b);
				if (idx >= 8'd30 && idx <= 8'd33)
					shadow.dst_addr = set_addr_byte(shadow.dst_addr, 12 + idx - 30, b);
			end else if (shadow.ether_word == pfke_pkg::ETHERTYPE_IPV6 && idx >= 8'd14) begin
				if (idx == 8'd20)
					shadow.proto = b;
				if (idx >= 8'd22 && idx <= 8'd37)
					shadow.src_addr = set_addr_byte(shadow.src_addr, idx - 22, b);
				if (idx >= 8'd38 && idx <= 8'd53)
					shadow.dst_addr = set_addr_byte(shadow.dst_addr, idx - 38, b);
			end
			// Transport fields at fixed offsets past the transport start
			if (shadow.transport_start != 8'd0 && idx > 8'd14 &&
					idx >= shadow.transport_start) begin
				off = int'(idx) - int'(shadow.transport_start);
				if (off < 4) begin
					ports = shadow.port_pair;
					ports[31 - 8 * off -: 8] = b;
					shadow.port_pair = ports;
				end else if (off == 12) begin
					shadow.tcp_header_bytes = {b[7:4], 2'b00};
				end else if (off == 13) begin
					shadow.tcp_flag_byte = b;
				end
			end
		end
		// Saturate the byte count for long frames
		len = (idx != 8'd255) ? int'(idx) + 1 : 255;
		shadow.byte_index = 8'(len);
		if (fb.last_byte) begin
			st = frame_status(len);
			done = 1'b1;
			key.status = st;
			key.ether_kind = shadow.ether_word;
			if (st == pfke_pkg::ST_OK) begin
				key.src_addr_high = shadow.src_addr[127:64];
				key.src_addr_low = shadow.src_addr[63:0];
				key.dst_addr_high = shadow.dst_addr[127:64];
				key.dst_addr_low = shadow.dst_addr[63:0];
				key.l4_proto = shadow.proto;
				key.source_port = shadow.port_pair[31:16];
				key.dest_port = shadow.port_pair[15:0];
				if (shadow.proto == pfke_pkg::PROTO_TCP) begin
					fl = {3'b000, shadow.tcp_flag_byte};
					// Both bits must be set, SYN-ACK first
					if (fl[pfke_pkg::FLAG_SYN_BIT] && fl[pfke_pkg::FLAG_ACK_BIT])
						fl[MARK_SYN_ACK_BIT] = 1'b1;
					else if (fl[pfke_pkg::FLAG_FIN_BIT] && fl[pfke_pkg::FLAG_ACK_BIT])
						fl[MARK_FIN_ACK_BIT] = 1'b1;
					else if (fl[pfke_pkg::FLAG_RST_BIT] && fl[pfke_pkg::FLAG_ACK_BIT])
						fl[MARK_RST_ACK_BIT] = 1'b1;
					key.flow_flags = fl;
				end
			end
			shadow = '0;
		end
	endtask

	// Fill frame_buf from a recipe: MACs, ethertype, IP header, transport
	// header, a little payload, then cut or pad to the requested length.
	task automatic build_frame(input frame_row_t row);
		logic [15:0] kind;
		logic [7:0]  proto;
		bit          is_v4;
		bit          is_v6;
		int          ip_len;
		int          l4_len;
		int          base;
		int          k;
		frame_buf.delete();
		if (row.shape == F_ALL_ZERO || row.shape == F_ALL_ONES) begin
			repeat (row.len)
				frame_buf.push_back(row.shape == F_ALL_ONES ? 8'hFF : 8'h00);
		end else begin
			is_v4 = (row.shape == F_V4_TCP || row.shape == F_V4_UDP || row.shape == F_V4_OTHER);
			is_v6 = (row.shape == F_V6_TCP || row.shape == F_V6_UDP || row.shape == F_V6_OTHER);
			kind = is_v4 ? pfke_pkg::ETHERTYPE_IPV4 :
				(is_v6 ? pfke_pkg::ETHERTYPE_IPV6 : ETHERTYPE_ARP);
			if (row.shape == F_V4_TCP || row.shape == F_V6_TCP) begin
				proto = pfke_pkg::PROTO_TCP;
			end else if (row.shape == F_V4_UDP || row.shape == F_V6_UDP) begin
				proto = pfke_pkg::PROTO_UDP;
			end else begin
				do
					proto = 8'($urandom_range(255));
				while (proto == pfke_pkg::PROTO_TCP || proto == pfke_pkg::PROTO_UDP);
			end
			repeat (12)
				frame_buf.push_back(8'($urandom_range(255)));
			frame_buf.push_back(kind[15:8]);
			frame_buf.push_back(kind[7:0]);
			if (is_v4) begin
				ip_len = (row.ihl < 5) ? 20 : row.ihl * 4;
				repeat (ip_len)
					frame_buf.push_back(8'($urandom_range(255)));
				frame_buf[14] = {4'h4, row.ihl[3:0]};
				frame_buf[23] = proto;
				if (row.twin)
					for (k = 0; k < 4; k++)
						frame_buf[30 + k] = frame_buf[26 + k];
			end else if (is_v6) begin
				repeat (40)
					frame_buf.push_back(8'($urandom_range(255)));
				frame_buf[14] = {4'h6, frame_buf[14][3:0]};
				frame_buf[20] = proto;
				if (row.twin)
					for (k = 0; k < 16; k++)
						frame_buf[38 + k] = frame_buf[22 + k];
			end else begin
				// ARP-sized body of noise
				repeat (46)
					frame_buf.push_back(8'($urandom_range(255)));
			end
			if (is_v4 || is_v6) begin
				base = frame_buf.size();
				if (proto == pfke_pkg::PROTO_TCP)
					l4_len = (row.doff * 4 > 20) ? row.doff * 4 : 20;
				else if (proto == pfke_pkg::PROTO_UDP)
					l4_len = UDP_HDR_LEN;
				else
					l4_len = $urandom_range(20, 8);
				repeat (l4_len)
					frame_buf.push_back(8'($urandom_range(255)));
				if (proto == pfke_pkg::PROTO_TCP) begin
					frame_buf[base + 12] = {row.doff[3:0], frame_buf[base + 12][3:0]};
					frame_buf[base + 13] = row.tcp_flags;
				end
			end
			repeat ($urandom_range(16))
				frame_buf.push_back(8'($urandom_range(255)));
		end
		if (row.len != 0) begin
			while (frame_buf.size() > row.len)
				void'(frame_buf.pop_back());
			while (frame_buf.size() < row.len)
				frame_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	// Random recipe: mostly well-formed frames with random content, some cut
	// short, the rest noise of any shape.
	task automatic pick_random_frame(output frame_row_t row);
		int pick;
		row = '0;
		pick = $urandom_range(99);
		row.shape = frame_shape_t'($urandom_range(int'(F_V6_UDP), int'(F_V4_TCP)));
		row.ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
		row.doff = ($urandom_range(3) == 0) ? $urandom_range(15, 0) : 5;
		row.tcp_flags = 8'($urandom_range(255));
		row.twin = ($urandom_range(19) == 0);
		if (pick < 3) begin
			row.len = $urandom_range(300, 240);
		end else if (pick >= 75 && pick < 88) begin
			row.len = $urandom_range(80, 1);
		end else if (pick >= 88) begin
			row.shape = frame_shape_t'($urandom_range(int'(F_ALL_ONES), int'(F_V4_TCP)));
			row.ihl = $urandom_range(15);
			if (row.shape == F_ALL_ZERO || row.shape == F_ALL_ONES || $urandom_range(1) == 0)
				row.len = $urandom_range(90, 1);
		end
	endtask

	// Send frame_buf one transfer at a time. Enter and leave at a falling
	// edge; hold valid and payload until the transfer happens.
	task automatic send_frame(input frame_row_t row);
		pfke_pkg::frame_byte_t fb;
		pfke_pkg::flow_key_t   want;
		bit                    done;
		int                    n;
		for (n = 0; n < frame_buf.size(); n++) begin
			while ($urandom_range(99) < src_idle_pct) begin
				byte_valid <= 1'b0;
				@(negedge clk);
			end
			fb.data_byte = frame_buf[n];
			fb.last_byte = (n == frame_buf.size() - 1);
			byte_valid <= 1'b1;
			byte_data <= fb;
			@(posedge clk);
			while (!byte_ready)
				@(posedge clk);
			track_byte(fb, done, want);
			if (done) begin
				if (row.typed) begin
					want = '0;
					want.status = row.st;
					want.ether_kind = row.ek;
				end
				pending_keys.push_back(want);
			end
			@(negedge clk);
		end
	endtask

	task automatic field_check(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Key side: drop ready at random, or hold it low for a long stretch when
	// the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			key_ready <= 1'b0;
		end else begin
			key_ready <= ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// Compare each key transfer with the oldest expected key.
	always @(posedge clk) begin : key_monitor
		pfke_pkg::flow_key_t want;
		if (arst_n && key_valid && key_ready) begin
			if (pending_keys.size() == 0) begin
				$display("%0t: flow key with none expected, expected nothing, got %h",
					$time, key_data);
				mismatch_count++;
			end else begin
				want = pending_keys.pop_front();
				field_check("status", want.status, key_data.status);
				field_check("ether_kind", want.ether_kind, key_data.ether_kind);
				field_check("src_addr_high", want.src_addr_high, key_data.src_addr_high);
				field_check("src_addr_low", want.src_addr_low, key_data.src_addr_low);
				field_check("dst_addr_high", want.dst_addr_high, key_data.dst_addr_high);
				field_check("dst_addr_low", want.dst_addr_low, key_data.dst_addr_low);
				field_check("l4_proto", want.l4_proto, key_data.l4_proto);
				field_check("source_port", want.source_port, key_data.source_port);
				field_check("dest_port", want.dest_port, key_data.dest_port);
				field_check("flow_flags", want.flow_flags, key_data.flow_flags);
			end
		end
	end

	// Watchdog: end a hung run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		frame_row_t row;
		int         phase;
		int         phase_bytes;
		int         n;
		// Hold reset, then release it at a falling edge
		repeat (6)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table, no idling
		for (n = 0; n < 25; n++) begin
			build_frame(directed_rows[n]);
			send_frame(directed_rows[n]);
		end

		// Random frames: no idling, sender idle, key side stalls, both
		for (phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin src_idle_pct = 55; rcv_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rcv_stall_pct = 55; end
				default: begin src_idle_pct = 38; rcv_stall_pct = 38; end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick_random_frame(row);
				build_frame(row);
				send_frame(row);
				phase_bytes += frame_buf.size();
			end
		end

		// Hold off the key side while short frames keep coming, so the result
		// register fills and the byte input stalls
		src_idle_pct = 0;
		rcv_stall_pct = 0;
		hold_req++;
		repeat (HOLD_FRAMES) begin
			row = '0;
			row.shape = F_V4_UDP;
			row.ihl = 5;
			row.len = 42;
			build_frame(row);
			send_frame(row);
		end
		byte_valid <= 1'b0;

		// Drain outstanding keys, then keep watching for stray keys
		while (pending_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
src/pfke_pkg.sv
src/pfke_parse.sv
src/packet_flow_key_extractor_core.sv
dv/packet_flow_key_extractor_core_test.sv
